[design/mbp_pkg.sv]
// shared types and constants of the msb-first bit packer
package mbp_pkg;

    localparam int ITEM_W    = 64;
    localparam int CNT_W     = 7;
    localparam int FREE_W    = 4;
    localparam int PTR_W     = 17;
    localparam int START_W   = 19;
    localparam int CAP_W     = 17;
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 2;

    localparam logic [15:0]      PREFIX_KEEP_MASK = 16'hff00;
    localparam logic [CAP_W-1:0] CAP_RESET        = 17'h10000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREFIX = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // outcome of one packing step
    typedef struct packed {
        logic [7:0]        part;
        logic [FREE_W-1:0] free;
        logic [CNT_W-1:0]  n_left;
        logic [FREE_W-1:0] take;
        logic              byte_done;
    } t_step_res;

endpackage

[design/mbp_step_unit.sv]
// step unit of the sequencer: merges the next up-to-eight field bits into the partial byte
module mbp_step_unit (
    input  logic [7:0]                 i_top,
    input  logic [mbp_pkg::CNT_W-1:0]  i_left,
    input  logic [mbp_pkg::FREE_W-1:0] i_free,
    input  logic [7:0]                 i_part,
    output mbp_pkg::t_step_res         o_res
);
    import mbp_pkg::*;

    logic [FREE_W-1:0] take;
    logic [7:0]        chunk;
    logic [FREE_W-1:0] free_new;

    always_comb begin
        if (i_left < CNT_W'(i_free)) begin
            take = i_left[FREE_W-1:0];
        end else begin
            take = i_free;
        end
        // top bits of the left-aligned field, right-justified
        chunk    = i_top >> (FREE_W'(8) - take);
        free_new = i_free - take;

        o_res.take      = take;
        o_res.free      = free_new;
        o_res.part      = i_part | (chunk << (i_free - take));
        o_res.n_left    = i_left - CNT_W'(take);
        o_res.byte_done = (free_new == '0);
    end

endmodule

[design/msb_first_bit_packer.sv]
// top level of the msb-first bit packer: sequencer, state and output register
//
// packs fields of 0 to 64 bits, high-order bit first, into a byte buffer
// and emits one byte write per result transaction.
// input channel s_axis: tdata carries the field value and its bit count.
// output channel m_axis: tdata carries address, byte value and unstored
// bit count; tlast marks the final result of an item; tuser carries the
// write-valid and overflow flags.
// configuration: i_cfg_we writes register i_cfg_index (0 start bit
// position, 1 capacity in bytes, 2 first byte prefix) at a rising edge.
// writing start or prefix reloads the packing state.
// timing: an item produces 1 to 9 results, one per cycle from the step
// unit, which handles one byte per cycle. the first result is stepped
// from the item registers that the input transaction loads; the next
// item is taken the cycle after the last result is loaded.
// a stall on m_axis holds the output register and freezes the step loop;
// the last result may wait while the next input transaction is taken.
// reset: start 0, capacity 65536, prefix 0, first byte at address 0.
module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = 64,
    parameter int ADDR_BITS      = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [mbp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mbp_pkg::CFG_W-1:0]       i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [71:0]                     s_axis_tdata,  // item_value[63:0], bit_count[70:64]
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [((ADDR_BITS+15+7)/8)*8-1:0] m_axis_tdata, // byte_address, byte_value, unstored_bits
    output logic                            m_axis_tlast,  // last_of_item
    output logic [1:0]                      m_axis_tuser   // write_valid, overflow_error
);
    import mbp_pkg::*;

    localparam int OUT_DATA_W = ((ADDR_BITS + 15 + 7) / 8) * 8;

    // configuration registers
    logic [START_W-1:0] r_start;
    logic [CAP_W-1:0]   r_cap;
    logic [7:0]         r_prefix;

    // packing state
    logic [7:0]         r_part;
    logic [FREE_W-1:0]  r_free;
    logic [PTR_W-1:0]   r_ptr;

    // current item
    logic [ITEM_W-1:0]  r_sh;
    logic [CNT_W-1:0]   r_left;
    logic               r_err;

    // output register
    logic                 r_out_valid;
    logic                 r_out_wv;
    logic [ADDR_BITS-1:0] r_out_addr;
    logic [7:0]           r_out_val;
    logic                 r_out_last;
    logic [CNT_W-1:0]     r_out_unstored;
    logic                 r_out_err;

    t_state    r_state;
    t_state    n_state;
    t_step_res step_res;
    logic      step_en;
    logic      in_acc;
    logic      out_free;
    logic      full_after;
    logic      step_last;

    logic [CNT_W-1:0]            in_cnt;
    logic [CNT_W-1:0]            in_sat;
    logic [START_W-1:0]          init_start;
    logic [7:0]                  init_prefix;
    logic [2:0]                  init_rem;
    logic [PTR_W-1:0]            ptr_inc;
    logic [PTR_W+ADDR_BITS-1:0]  ptr_wide;

    // buffer is full when the pointer reaches capacity or the address space
    function automatic logic is_full(input logic [PTR_W-1:0] p, input logic [CAP_W-1:0] cap);
        logic [PTR_W+ADDR_BITS-1:0] w;
        w = {ADDR_BITS'(0), p};
        return (CAP_W'(p) >= cap) || (w[PTR_W+ADDR_BITS-1:ADDR_BITS] != '0);
    endfunction

    mbp_step_unit u_step (
        .i_top  (r_sh[ITEM_W-1 -: 8]),
        .i_left (r_left),
        .i_free (r_free),
        .i_part (r_part),
        .o_res  (step_res)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_en && step_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        out_free      = !r_out_valid || m_axis_tready;
        s_axis_tready = (r_state == ST_IDLE);
        step_en       = (r_state == ST_RUN) && out_free;
    end

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // saturate the count to the widest supported field
    assign in_cnt = s_axis_tdata[70:64];
    assign in_sat = (in_cnt > CNT_W'(MAX_FIELD_BITS)) ? CNT_W'(MAX_FIELD_BITS) : in_cnt;

    assign ptr_inc    = r_ptr + PTR_W'(1);
    assign full_after = is_full(ptr_inc, r_cap);
    assign step_last  = r_err || !step_res.byte_done || full_after;
    assign ptr_wide   = {ADDR_BITS'(0), r_ptr};

    // start and prefix after a pending configuration write
    assign init_start  = (i_cfg_index == CFG_START) ? i_cfg_data[START_W-1:0] : r_start;
    assign init_prefix = (i_cfg_index == CFG_PREFIX) ? i_cfg_data[7:0] : r_prefix;
    assign init_rem    = init_start[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= '0;
            r_cap       <= CAP_RESET;
            r_prefix    <= '0;
            r_part      <= '0;
            r_free      <= FREE_W'(8);
            r_ptr       <= '0;
            r_err       <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CAP: r_cap <= i_cfg_data[CAP_W-1:0];
                    CFG_START, CFG_PREFIX: begin
                        r_start  <= init_start;
                        r_prefix <= init_prefix;
                        r_part   <= init_prefix & PREFIX_KEEP_MASK[init_rem + 4'd7 -: 8];
                        r_free   <= FREE_W'(8) - FREE_W'(init_rem);
                        r_ptr    <= PTR_W'(init_start[START_W-1:3]);
                    end
                    default: ;
                endcase
            end else if (step_en && !r_err) begin
                if (step_res.byte_done) begin
                    r_ptr  <= ptr_inc;
                    r_part <= '0;
                    r_free <= FREE_W'(8);
                end else begin
                    r_part <= step_res.part;
                    r_free <= step_res.free;
                end
            end

            if (in_acc) begin
                r_left <= in_sat;
                r_err  <= is_full(r_ptr, r_cap);
            end else if (step_en) begin
                r_left <= step_res.n_left;
            end

            if (step_en) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            // left-align the field so bits above the count fall off
            r_sh <= s_axis_tdata[ITEM_W-1:0] << (CNT_W'(ITEM_W) - in_sat);
        end else if (step_en) begin
            r_sh <= r_sh << step_res.take;
        end

        if (step_en) begin
            if (r_err) begin
                // buffer already full: flag only, nothing written
                r_out_wv       <= 1'b0;
                r_out_addr     <= '0;
                r_out_val      <= '0;
                r_out_last     <= 1'b1;
                r_out_unstored <= r_left;
                r_out_err      <= 1'b1;
            end else begin
                r_out_wv       <= 1'b1;
                r_out_addr     <= ptr_wide[ADDR_BITS-1:0];
                r_out_val      <= step_res.part;
                r_out_last     <= step_last;
                r_out_unstored <= step_last ? step_res.n_left : '0;
                r_out_err      <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'({r_out_unstored, r_out_val, r_out_addr});
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = {r_out_err, r_out_wv};

    // an overflow result never carries a write and always ends the item
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_err |-> r_out_last && !r_out_wv)
        else $error("overflow result without last or with a write");

    // while a non-final result waits, the item is still being packed
    a_busy_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> !s_axis_tready)
        else $error("input taken in the middle of an item");

    // free bit count stays within one byte
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free != '0) && (r_free <= FREE_W'(8)))
        else $error("free bit count out of range");

    // unstored bits are only reported on the final result
    a_unstored_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_unstored != '0) |-> r_out_last)
        else $error("unstored bits on a non-final result");

    // every step loads its result into the output register
    a_step_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en |=> r_out_valid)
        else $error("step did not load the output register");

endmodule

[tb/sv/tb_msb_first_bit_packer.sv]
// self-checking testbench of the msb-first bit packer with its own packing predictor
module tb_msb_first_bit_packer;
    import mbp_pkg::*;

    localparam int MAX_FIELD_BITS = 64;
    localparam int ADDR_BITS      = 16;
    localparam int ADDR_SPACE     = 1 << ADDR_BITS;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 60;
    localparam int HOLD_AT_ITEM   = 170;   // middle of the third random phase
    localparam int HOLD_CYCLES    = 400;

    // one result transaction as the block reports it
    typedef struct {
        logic        wv;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        last;
        logic [6:0]  unstored;
        logic        err;
    } t_byte_write;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    // one line of the directed stimulus table
    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_data;
        logic [63:0]           value;
        logic [6:0]            count;
        logic                  typed;
        t_byte_write           want;
    } t_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = CFG_START;
    logic [CFG_W-1:0]           i_cfg_data = '0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [71:0]                s_axis_tdata = '0;   // item_value[63:0], bit_count[70:64]
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [31:0]                m_axis_tdata;   // byte_address[15:0], byte_value[23:16],
                                                // unstored_bits[30:24]
    logic                       m_axis_tlast;   // last_of_item
    logic [1:0]                 m_axis_tuser;   // write_valid[0], overflow_error[1]

    msb_first_bit_packer #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .ADDR_BITS     (ADDR_BITS)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register copies and packing state of the predictor
    logic [18:0]   start_reg;
    logic [16:0]   cap_reg;
    logic [7:0]    prefix_reg;
    logic [7:0]    acc_byte;     // partial byte being filled
    logic [3:0]    acc_free;     // unfilled low bits of acc_byte
    logic [16:0]   wr_ptr;       // byte address of acc_byte

    t_byte_write   byte_writes_q[$];   // writes still owed by the block
    t_byte_write   field_writes[$];    // writes of the field just packed
    t_row          dir_rows[$];

    int            mismatches = 0;
    int            items_taken = 0;
    int            burst_left = 0;

    // packing state restarts from start position and prefix, as at reset
    function void reload_packer();
        logic [2:0] rem;
        logic [15:0] keep;
        rem = start_reg[2:0];
        keep = PREFIX_KEEP_MASK >> rem;
        acc_byte = prefix_reg & keep[7:0];
        acc_free = 4'd8 - rem;
        wr_ptr = {1'b0, start_reg[18:3]};
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_START: begin
                start_reg = data[18:0];
                reload_packer();
            end
            CFG_CAP: begin
                cap_reg = data[16:0];
            end
            CFG_PREFIX: begin
                prefix_reg = data[7:0];
                reload_packer();
            end
            default: begin
            end
        endcase
    endfunction

    // packs one field msb first and leaves its byte writes in field_writes
    function void pack_field(input logic [63:0] value, input logic [6:0] count);
        logic [63:0] v;
        logic [63:0] shifted;
        int          n;
        int          take;
        int          mask;
        int          cap;
        logic [7:0]  chunk;
        t_byte_write w;
        field_writes.delete();
        cap = (cap_reg > ADDR_SPACE) ? ADDR_SPACE : int'(cap_reg);
        n = (count > MAX_FIELD_BITS) ? MAX_FIELD_BITS : int'(count);
        v = value;
        if (n < 64)
            v = v & ((64'd1 << n) - 64'd1);
        // buffer already full: a lone error result, nothing written
        if (wr_ptr >= cap) begin
            w = '{1'b0, 16'h0, 8'h00, 1'b1, 7'(n), 1'b1};
            field_writes.push_back(w);
            return;
        end
        while (n > 0) begin
            take = (n < acc_free) ? n : int'(acc_free);
            shifted = v >> (n - take);
            mask = (1 << take) - 1;
            chunk = shifted[7:0] & mask[7:0];
            n = n - take;
            acc_byte = acc_byte | (chunk << (acc_free - take));
            acc_free = acc_free - 4'(take);
            if (acc_free == 0) begin
                w = '{1'b1, wr_ptr[15:0], acc_byte, 1'b0, 7'd0, 1'b0};
                field_writes.push_back(w);
                wr_ptr = wr_ptr + 17'd1;
                acc_byte = 8'h00;
                acc_free = 4'd8;
                if (wr_ptr >= cap)
                    break;
            end
        end
        // current partial byte follows unless the buffer just filled
        if (wr_ptr < cap) begin
            w = '{1'b1, wr_ptr[15:0], acc_byte, 1'b0, 7'd0, 1'b0};
            field_writes.push_back(w);
        end
        field_writes[field_writes.size()-1].last = 1'b1;
        field_writes[field_writes.size()-1].unstored = 7'(n);
    endfunction

    // result side: every transaction is matched against the oldest owed write
    always @(posedge i_clk) begin
        t_byte_write want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (byte_writes_q.size() == 0) begin
                $error("result transaction with no write expected");
                mismatches++;
            end else begin
                want = byte_writes_q.pop_front();
                if (m_axis_tuser[0] !== want.wv) begin
                    $error("write_valid mismatch: expected %0h, actual %0h",
                           want.wv, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tdata[15:0] !== want.addr) begin
                    $error("byte_address mismatch: expected %0h, actual %0h",
                           want.addr, m_axis_tdata[15:0]);
                    mismatches++;
                end
                if (m_axis_tdata[23:16] !== want.data) begin
                    $error("byte_value mismatch: expected %0h, actual %0h",
                           want.data, m_axis_tdata[23:16]);
                    mismatches++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last_of_item mismatch: expected %0h, actual %0h",
                           want.last, m_axis_tlast);
                    mismatches++;
                end
                if (m_axis_tdata[30:24] !== want.unstored) begin
                    $error("unstored_bits mismatch: expected %0d, actual %0d",
                           want.unstored, m_axis_tdata[30:24]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.err) begin
                    $error("overflow_error mismatch: expected %0h, actual %0h",
                           want.err, m_axis_tuser[1]);
                    mismatches++;
                end
                if (m_axis_tdata[31] !== 1'b0) begin
                    $error("tdata pad mismatch: expected 0, actual %0h", m_axis_tdata[31]);
                    mismatches++;
                end
            end
        end
    end

    // receiver: segments of full rate, random stalls and a sparse pattern,
    // plus one long hold-off so the block backs up into its input
    initial begin
        int  mode;
        int  seg_len;
        int  cyc;
        bit  held;
        held = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            seg_len = $urandom_range(10, 60);
            for (cyc = 0; cyc < seg_len; cyc++) begin
                if (!held && items_taken >= HOLD_AT_ITEM) begin
                    held = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge i_clk);
                end
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                    default: m_axis_tready <= (cyc % 3 == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // one register write; the enable drops for a cycle before the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        set_reg(idx, data);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait until every owed write has come back
    task automatic drain_writes();
        s_axis_tvalid <= 1'b0;
        while (byte_writes_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // offers one field and waits for its transaction; the sender runs in
    // bursts, so valid only drops between bursts
    task automatic offer_field(input logic [63:0] value, input logic [6:0] count,
                               input bit typed, input t_byte_write want);
        int gap;
        s_axis_tdata <= {1'b0, count, value};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        items_taken++;
        pack_field(value, count);
        if (typed)
            byte_writes_q.push_back(want);
        else
            foreach (field_writes[i])
                byte_writes_q.push_back(field_writes[i]);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    function void add_item(input logic [63:0] value, input logic [6:0] count);
        t_row r;
        r = '{ROW_ITEM, CFG_START, '0, value, count, 1'b0, '{1'b0, 16'h0, 8'h0, 1'b0, 7'd0, 1'b0}};
        dir_rows.push_back(r);
    endfunction

    function void add_checked(input logic [63:0] value, input logic [6:0] count,
                              input t_byte_write want);
        t_row r;
        r = '{ROW_ITEM, CFG_START, '0, value, count, 1'b1, want};
        dir_rows.push_back(r);
    endfunction

    function void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        t_row r;
        r = '{ROW_CFG, idx, data, 64'h0, 7'd0, 1'b0, '{1'b0, 16'h0, 8'h0, 1'b0, 7'd0, 1'b0}};
        dir_rows.push_back(r);
    endfunction

    initial begin
        t_byte_write      none;
        logic [CFG_IDX_W-1:0] reg_ids[3];
        logic [CFG_W-1:0] reg_vals[3];
        logic [63:0]      value;
        logic [6:0]       count;
        int               ph;
        int               k;
        int               rot;
        int               sel;
        int               start_top;
        none = '{1'b0, 16'h0, 8'h0, 1'b0, 7'd0, 1'b0};
        reg_ids = '{CFG_START, CFG_CAP, CFG_PREFIX};

        // predictor starts from the reset values of the registers
        start_reg = '0;
        cap_reg = CAP_RESET;
        prefix_reg = 8'h00;
        reload_packer();

        // directed part, from reset: start 0, full capacity, prefix 0
        // zero count rewrites byte 0 unchanged; high value bits are ignored
        add_checked(64'hffff_ffff_ffff_ffff, 7'd0, '{1'b1, 16'h0000, 8'h00, 1'b1, 7'd0, 1'b0});
        add_item(64'h1, 7'd1);
        add_item(64'h7f, 7'd7);
        add_item(64'hffff_ffff_ffff_ffff, 7'd64);
        add_item(64'h8000_0000_0000_0001, 7'd64);
        // counts above the field width saturate to 64
        add_item(64'h0123_4567_89ab_cdef, 7'd127);
        add_item(64'hfedc_ba98_7654_3210, 7'd65);
        add_item(64'hffff_ffff_ffff_fffd, 7'd3);
        // unaligned start keeps the top five bits of the prefix
        add_cfg(CFG_START, 19'd13);
        add_cfg(CFG_PREFIX, 19'hff);
        add_checked(64'h0, 7'd0, '{1'b1, 16'h0001, 8'hf8, 1'b1, 7'd0, 1'b0});
        add_item(64'h7, 7'd3);
        // two-byte buffer filled from byte 1: no partial byte after it
        add_cfg(CFG_CAP, 19'd2);
        add_cfg(CFG_START, 19'd8);
        add_cfg(CFG_PREFIX, 19'h0);
        add_checked(64'hffff_ffff_ffff_ffff, 7'd64, '{1'b1, 16'h0001, 8'hff, 1'b1, 7'd56, 1'b0});
        // buffer already full: error results
        add_checked(64'h1f, 7'd5, '{1'b0, 16'h0000, 8'h00, 1'b1, 7'd5, 1'b1});
        add_checked(64'h0, 7'd127, '{1'b0, 16'h0000, 8'h00, 1'b1, 7'd64, 1'b1});
        // oversized capacity clamps to the address space; last bit of the buffer
        add_cfg(CFG_CAP, 19'd131071);
        add_cfg(CFG_START, 19'd524287);
        add_checked(64'h1, 7'd1, '{1'b1, 16'hffff, 8'h01, 1'b1, 7'd0, 1'b0});
        add_checked(64'h3ff, 7'd10, '{1'b0, 16'h0000, 8'h00, 1'b1, 7'd10, 1'b1});
        // single-byte buffer overrun in the middle of a field
        add_cfg(CFG_CAP, 19'd1);
        add_cfg(CFG_START, 19'd0);
        add_checked(64'h1ff, 7'd9, '{1'b1, 16'h0000, 8'hff, 1'b1, 7'd1, 1'b0});
        // prefix written after start, offset 3
        add_cfg(CFG_CAP, 19'd65536);
        add_cfg(CFG_START, 19'd3);
        add_cfg(CFG_PREFIX, 19'hab);
        add_checked(64'h0, 7'd0, '{1'b1, 16'h0000, 8'ha0, 1'b1, 7'd0, 1'b0});
        add_item(64'h1555, 7'd13);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                if (i > 0 && dir_rows[i-1].kind == ROW_ITEM)
                    drain_writes();
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            end else begin
                offer_field(dir_rows[i].value, dir_rows[i].count, dir_rows[i].typed,
                            dir_rows[i].want);
            end
        end

        // random phases, each under its own register setting
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            drain_writes();
            reg_vals[2] = CFG_W'($urandom_range(0, 255));
            case (ph)
                0: begin
                    reg_vals[1] = CFG_W'(65536);
                    reg_vals[0] = CFG_W'($urandom_range(0, 64));
                end
                1: begin
                    reg_vals[1] = CFG_W'(1);
                    reg_vals[0] = '0;
                end
                2: begin
                    reg_vals[1] = CFG_W'(131071);
                    reg_vals[0] = CFG_W'(524287 - $urandom_range(0, 2000));
                    reg_vals[2] = CFG_W'(255);
                end
                RAND_PHASES - 1: begin
                    // back to the reset setting
                    reg_vals[1] = CFG_W'(65536);
                    reg_vals[0] = '0;
                    reg_vals[2] = '0;
                end
                default: begin
                    sel = $urandom_range(0, 3);
                    case (sel)
                        0: reg_vals[1] = CFG_W'($urandom_range(1, 64));
                        1: reg_vals[1] = CFG_W'($urandom_range(1, 131071));
                        2: reg_vals[1] = CFG_W'(65536);
                        default: reg_vals[1] = CFG_W'(131071);
                    endcase
                    // start mostly inside or just past the buffer
                    start_top = int'(reg_vals[1]) * 8 + 40;
                    if (start_top > 524287)
                        start_top = 524287;
                    reg_vals[0] = CFG_W'($urandom_range(0, start_top));
                end
            endcase
            rot = $urandom_range(0, 2);
            for (k = 0; k < 3; k++)
                write_reg(reg_ids[(rot + k) % 3], reg_vals[(rot + k) % 3]);

            for (k = 0; k < PHASE_ITEMS; k++) begin
                sel = $urandom_range(0, 9);
                if (sel < 7)
                    count = 7'($urandom_range(0, 64));
                else if (sel == 7)
                    count = ($urandom_range(0, 1) == 1) ? 7'd64 : 7'd0;
                else
                    count = 7'($urandom_range(65, 127));
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    value = '1;
                else if (sel == 1)
                    value = '0;
                else
                    value = {$urandom, $urandom};
                offer_field(value, count, 1'b0, none);
            end
        end

        drain_writes();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && byte_writes_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
